// File: rtl/tharc_pkg.sv
// Shared constants for the two-hand shortest-arc interpolator.
package tharc_pkg;

  localparam int ANGLE_FRAC_BITS = 4;
  localparam int ANGLE_W = 13;
  localparam int MAG_W = 12;
  localparam int SCALE_W = 16;
  localparam int SCALE_SHIFT = ANGLE_FRAC_BITS + 8;
  localparam int TDATA_W = 32;
  localparam int MAX_STEPS_DEFAULT = 63;

  localparam logic [ANGLE_W-1:0] FULL_CIRCLE = ANGLE_W'(360 << ANGLE_FRAC_BITS);
  localparam logic [MAG_W-1:0] HALF_CIRCLE = MAG_W'(180 << ANGLE_FRAC_BITS);
  localparam logic [ANGLE_W-1:0] RESET_ANGLE = ANGLE_W'(45 << ANGLE_FRAC_BITS);
  localparam logic [SCALE_W-1:0] STEP_SCALE_RESET = SCALE_W'(64);

endpackage

// File: rtl/two_hand_shortest_arc_interpolator.sv
// Top level: two-hand shortest-arc interpolator with stream ports and a scale register.
// Each input beat carries two target angles (sixteenths of a degree). The block may swap
// them between the hands to reduce the total raw move, then walks both hands along their
// shortest arcs in steps+1 output beats, steps = floor(longest arc * step_scale), clamped
// to [1, MAX_STEPS]; the final beat carries tlast. Before the first output beat the shared
// radix-2 divider runs two passes (12 quotient bits each) that split each arc by the step
// count. Each output beat then passes through the LOAD and EMIT states and is held while
// the output side stalls. Input is accepted only between moves. step_scale (unsigned Q8.8)
// is written via the cfg port.
module two_hand_shortest_arc_interpolator #(
  parameter int MAX_STEPS = tharc_pkg::MAX_STEPS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  // cfg_data: step_scale
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [tharc_pkg::SCALE_W-1:0] cfg_data,
  // s_axis_tdata: [12:0] target_a, [25:13] target_b, rest zero
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [tharc_pkg::TDATA_W-1:0] s_axis_tdata,
  // m_axis_tdata: [12:0] angle_a, [25:13] angle_b, rest zero; tlast is last_step
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [tharc_pkg::TDATA_W-1:0] m_axis_tdata,
  output logic                          m_axis_tlast
);

  localparam int STEP_W = $clog2(MAX_STEPS + 1);
  localparam int AW = tharc_pkg::ANGLE_W;
  localparam int MW = tharc_pkg::MAG_W;
  localparam int PROD_W = tharc_pkg::MAG_W + tharc_pkg::SCALE_W;

  typedef enum logic [3:0] {
    IDLE, COST, DELTA, SCALE, DIVA_GO, DIVA_WAIT, DIVB_GO, DIVB_WAIT, LOAD, EMIT
  } state_t;

  typedef struct packed {
    logic          neg;
    logic [MW-1:0] mag;
  } arc_t;

  typedef struct packed {
    logic [MW-1:0]     q;
    logic [STEP_W-1:0] r;
  } acc_t;

  function automatic logic [AW-1:0] abs_diff(input logic [AW-1:0] x, input logic [AW-1:0] y);
    return (x > y) ? AW'(x - y) : AW'(y - x);
  endfunction

  function automatic logic [AW-1:0] reduce(input logic [AW-1:0] t);
    return (t >= tharc_pkg::FULL_CIRCLE) ? AW'(t - tharc_pkg::FULL_CIRCLE) : t;
  endfunction

  // signed shortest delta in [-HALF, HALF)
  function automatic arc_t shortest(input logic [AW-1:0] from, input logic [AW-1:0] to);
    logic signed [AW:0] d;
    logic signed [AW:0] dn;
    arc_t a;
    d = $signed({1'b0, to}) - $signed({1'b0, from});
    if (d >= $signed({2'b0, tharc_pkg::HALF_CIRCLE})) begin
      d = d - $signed({1'b0, tharc_pkg::FULL_CIRCLE});
    end else if (d < -$signed({2'b0, tharc_pkg::HALF_CIRCLE})) begin
      d = d + $signed({1'b0, tharc_pkg::FULL_CIRCLE});
    end
    dn = -d;
    a.neg = d[AW];
    a.mag = a.neg ? MW'(dn) : MW'(d);
    return a;
  endfunction

  // advance floor(mag*i/steps) by one i using the split mag = q0*steps + r0
  function automatic acc_t advance(input acc_t cur, input acc_t base,
                                   input logic [STEP_W-1:0] div);
    logic [STEP_W:0] sr;
    acc_t nx;
    sr = {1'b0, cur.r} + {1'b0, base.r};
    if (sr >= {1'b0, div}) begin
      nx.r = STEP_W'(sr - {1'b0, div});
      nx.q = MW'(cur.q + base.q + 1'b1);
    end else begin
      nx.r = sr[STEP_W-1:0];
      nx.q = MW'(cur.q + base.q);
    end
    return nx;
  endfunction

  function automatic logic [AW-1:0] place(input logic [AW-1:0] from, input logic neg,
                                          input logic [MW-1:0] q);
    logic [AW:0] t;
    if (neg) begin
      t = {1'b0, from} - {2'b0, q};
      if (t[AW]) begin
        t = t + {1'b0, tharc_pkg::FULL_CIRCLE};
      end
    end else begin
      t = {1'b0, from} + {2'b0, q};
      if (t >= {1'b0, tharc_pkg::FULL_CIRCLE}) begin
        t = t - {1'b0, tharc_pkg::FULL_CIRCLE};
      end
    end
    return t[AW-1:0];
  endfunction

  state_t                        state;
  logic [tharc_pkg::SCALE_W-1:0] step_scale;
  logic [AW-1:0]                 cur_a, cur_b, tgt_a, tgt_b;
  arc_t                          arc_a, arc_b;
  logic [STEP_W-1:0]             steps, idx;
  acc_t                          base_a, base_b, acc_a, acc_b;

  logic [AW:0]                   cost_keep, cost_swap;
  arc_t                          arc_a_next, arc_b_next;
  logic [MW-1:0]                 max_len;
  logic [PROD_W-1:0]             prod;
  logic [tharc_pkg::SCALE_W-1:0] scaled;
  logic [STEP_W-1:0]             steps_next;
  acc_t                          acc_a_next, acc_b_next;

  logic                          div_start, div_done;
  logic [MW-1:0]                 div_quo;
  logic [STEP_W-1:0]             div_rem;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = (state == IDLE);

  always_comb begin
    cost_keep  = {1'b0, abs_diff(tgt_a, cur_a)} + {1'b0, abs_diff(tgt_b, cur_b)};
    cost_swap  = {1'b0, abs_diff(tgt_b, cur_a)} + {1'b0, abs_diff(tgt_a, cur_b)};
    arc_a_next = shortest(cur_a, tgt_a);
    arc_b_next = shortest(cur_b, tgt_b);
    max_len    = (arc_a.mag > arc_b.mag) ? arc_a.mag : arc_b.mag;
    prod       = PROD_W'(max_len) * PROD_W'(step_scale);
    scaled     = tharc_pkg::SCALE_W'(prod >> tharc_pkg::SCALE_SHIFT);
    if (scaled == '0) begin
      steps_next = STEP_W'(1);
    end else if (scaled > tharc_pkg::SCALE_W'(MAX_STEPS)) begin
      steps_next = STEP_W'(MAX_STEPS);
    end else begin
      steps_next = scaled[STEP_W-1:0];
    end
    acc_a_next = advance(acc_a, base_a, steps);
    acc_b_next = advance(acc_b, base_b, steps);
  end

  assign div_start = (state == DIVA_GO) || (state == DIVB_GO);

  tharc_div #(
    .STEP_W(STEP_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend ((state == DIVA_GO) ? arc_a.mag : arc_b.mag),
    .divisor  (steps),
    .done     (div_done),
    .quotient (div_quo),
    .remainder(div_rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= IDLE;
      step_scale    <= tharc_pkg::STEP_SCALE_RESET;
      cur_a         <= tharc_pkg::RESET_ANGLE;
      cur_b         <= tharc_pkg::RESET_ANGLE;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        step_scale <= cfg_data;
      end
      case (state)
        IDLE: begin
          if (s_axis_tvalid) begin
            tgt_a <= reduce(s_axis_tdata[AW-1:0]);
            tgt_b <= reduce(s_axis_tdata[2*AW-1:AW]);
            state <= COST;
          end
        end
        COST: begin
          if (cost_swap < cost_keep) begin
            tgt_a <= tgt_b;
            tgt_b <= tgt_a;
          end
          state <= DELTA;
        end
        DELTA: begin
          arc_a <= arc_a_next;
          arc_b <= arc_b_next;
          state <= SCALE;
        end
        SCALE: begin
          steps <= steps_next;
          state <= DIVA_GO;
        end
        DIVA_GO: state <= DIVA_WAIT;
        DIVA_WAIT: begin
          if (div_done) begin
            base_a <= '{q: div_quo, r: div_rem};
            state  <= DIVB_GO;
          end
        end
        DIVB_GO: state <= DIVB_WAIT;
        DIVB_WAIT: begin
          if (div_done) begin
            base_b <= '{q: div_quo, r: div_rem};
            acc_a  <= '0;
            acc_b  <= '0;
            idx    <= '0;
            state  <= LOAD;
          end
        end
        LOAD: begin
          m_axis_tdata  <= {(tharc_pkg::TDATA_W - 2*AW)'(0),
                            place(cur_b, arc_b.neg, acc_b.q),
                            place(cur_a, arc_a.neg, acc_a.q)};
          m_axis_tlast  <= (idx == steps);
          m_axis_tvalid <= 1'b1;
          state         <= EMIT;
        end
        EMIT: begin
          if (m_axis_tready) begin
            m_axis_tvalid <= 1'b0;
            if (m_axis_tlast) begin
              // final beat lands exactly on the targets
              cur_a <= tgt_a;
              cur_b <= tgt_b;
              state <= IDLE;
            end else begin
              idx   <= idx + 1'b1;
              acc_a <= acc_a_next;
              acc_b <= acc_b_next;
              state <= LOAD;
            end
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  a_no_input_while_output: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> !m_axis_tvalid)
    else $error("input ready while an output beat is pending");

  a_angles_normalized: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[AW-1:0] < tharc_pkg::FULL_CIRCLE) &&
                      (m_axis_tdata[2*AW-1:AW] < tharc_pkg::FULL_CIRCLE))
    else $error("output angle out of range");

  a_step_bounds: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (steps != '0) && (idx <= steps) &&
                      (steps <= STEP_W'(MAX_STEPS)))
    else $error("step index or step count out of range");

  a_ready_after_last: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> s_axis_tready)
    else $error("block not ready after final beat");

endmodule

// File: rtl/tharc_div.sv
// Iterative restoring divider: arc magnitude by step count, one quotient bit per cycle.
module tharc_div #(
  parameter int STEP_W = 6
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [tharc_pkg::MAG_W-1:0] dividend,
  input  logic [STEP_W-1:0]           divisor,
  output logic                        done,
  output logic [tharc_pkg::MAG_W-1:0] quotient,
  output logic [STEP_W-1:0]           remainder
);

  localparam int CNT_W = $clog2(tharc_pkg::MAG_W);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [STEP_W:0]  trial;
  logic             fits;

  assign trial = {remainder, quotient[tharc_pkg::MAG_W-1]};
  assign fits  = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy      <= 1'b1;
        cnt       <= CNT_W'(tharc_pkg::MAG_W - 1);
        remainder <= '0;
        quotient  <= dividend;
      end else if (busy) begin
        // shift in the next dividend bit, subtract when the divisor fits
        if (fits) begin
          remainder <= STEP_W'(trial - {1'b0, divisor});
        end else begin
          remainder <= trial[STEP_W-1:0];
        end
        quotient <= {quotient[tharc_pkg::MAG_W-2:0], fits};
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

endmodule
